>>> rtl/ccs_pkg.sv
// Package for the column cosine similarity lock check.
// Holds widths, limits and defaults shared by all design files; no dependencies.
package ccs_pkg;
	localparam int PIX_W = 8;
	localparam int ACC_W = 27;
	localparam int SUM_W = 26;
	localparam int SIM_W = 16;
	localparam int CNT_W = 11;
	localparam int THR_W = 16;
	localparam int NUM_INPUT_FRAMES = 6;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_HISTORY_FRAMES = 6;
	localparam logic [THR_W-1:0] THR_RESET = 16'd6554;
	localparam logic [SIM_W-1:0] ONE_Q15 = 16'd32768;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef struct packed {
		logic [PIX_W-1:0] cur_pixel;
		logic [PIX_W-1:0] hist_pixel_1;
		logic [PIX_W-1:0] hist_pixel_2;
		logic [PIX_W-1:0] hist_pixel_3;
		logic [PIX_W-1:0] hist_pixel_4;
		logic [PIX_W-1:0] hist_pixel_5;
		logic [PIX_W-1:0] hist_pixel_6;
		logic column_end;
		logic frame_end;
	} pix_beat_t;

	typedef struct packed {
		logic [SIM_W-1:0] avg_similarity;
		logic lost_lock;
		logic [CNT_W-1:0] column_count;
	} res_beat_t;

	// Lane control from the sequencer.
	typedef struct packed {
		logic acc_en;
		logic col_close;
		logic take;
		logic frame_clear;
	} lane_ctl_t;
endpackage

>>> rtl/ccs_if.sv
// Valid/ready stream interface for pixel and result beats.
// Depends on ccs_pkg.
interface ccs_pix_if;
	import ccs_pkg::*;
	logic valid;
	logic ready;
	pix_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ccs_res_if;
	import ccs_pkg::*;
	logic valid;
	logic ready;
	res_beat_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ccs_lane.sv
// One history-frame lane: accumulators, iterative square-root style search of the
// column similarity, and the saturating similarity sum. Depends on ccs_pkg.
module ccs_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic [ccs_pkg::PIX_W-1:0] cur_pixel,
	input  logic [ccs_pkg::PIX_W-1:0] hist_pixel,
	input  ccs_pkg::lane_ctl_t ctl,
	input  logic [ccs_pkg::ACC_W-1:0] cur_norm,
	output logic [ccs_pkg::SUM_W-1:0] sim_sum,
	output logic busy
);
	import ccs_pkg::*;

	logic [ACC_W-1:0] dot_q, hnorm_q;
	logic [ACC_W-1:0] dot_n, hnorm_n;
	logic [SUM_W-1:0] sum_q;
	logic [ACC_W-1:0] sdot_q, sca_q, scb_q;
	logic [83:0] rhs_q;
	logic [89:0] sq_q, lin_q, pw_q;
	logic [89:0] cand, lin_up;
	logic [16:0] res_q;
	logic [4:0] bit_q;
	logic [1:0] phase_q;
	logic pend_q;
	logic take_bit;
	logic [16:0] trial, sim_c;
	logic [27:0] dsum, hsum;
	logic [SUM_W:0] ssum;

	// The search keeps res*res*prod, res*prod shifted and prod shifted in registers, so
	// each trial needs only adds and a compare.
	always_comb begin
		dsum = {1'b0, dot_q} + 28'(16'(cur_pixel) * 16'(hist_pixel));
		hsum = {1'b0, hnorm_q} + 28'(16'(hist_pixel) * 16'(hist_pixel));
		dot_n = dsum[ACC_W] ? ACC_MAX : dsum[ACC_W-1:0];
		hnorm_n = hsum[ACC_W] ? ACC_MAX : hsum[ACC_W-1:0];
		trial = res_q | (17'd1 << bit_q);
		cand = sq_q + lin_q + pw_q;
		take_bit = pend_q && ({6'd0, rhs_q} >= cand);
		lin_up = take_bit ? lin_q + (pw_q << 1) : lin_q;
		sim_c = (res_q > 17'(ONE_Q15)) ? 17'(ONE_Q15) : res_q;
		ssum = {1'b0, sum_q} + {{(SUM_W-16){1'b0}}, sim_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			hnorm_q <= '0;
			sum_q <= '0;
			phase_q <= 2'd0;
			pend_q <= 1'b0;
			bit_q <= '0;
			res_q <= '0;
		end else begin
			if (ctl.acc_en) begin
				if (ctl.col_close) begin
					dot_q <= '0;
					hnorm_q <= '0;
				end else begin
					dot_q <= dot_n;
					hnorm_q <= hnorm_n;
				end
			end
			case (phase_q)
				2'd0: begin
					if (ctl.acc_en && ctl.col_close && ctl.take) begin
						sdot_q <= dot_n;
						sca_q <= cur_norm;
						scb_q <= hnorm_n;
						phase_q <= 2'd1;
					end
				end
				2'd1: begin
					pw_q <= 90'({27'd0, sca_q} * {27'd0, scb_q}) << 32;
					rhs_q <= {30'd0, {27'd0, sdot_q} * {27'd0, sdot_q}} << 30;
					sq_q <= '0;
					lin_q <= '0;
					res_q <= '0;
					bit_q <= 5'd16;
					pend_q <= (sca_q != '0) && (scb_q != '0);
					phase_q <= 2'd2;
				end
				2'd2: begin
					if (take_bit) begin
						res_q <= trial;
						sq_q <= cand;
					end
					lin_q <= lin_up >> 1;
					pw_q <= pw_q >> 2;
					if (bit_q == 5'd0) begin
						phase_q <= 2'd3;
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
				default: begin
					sum_q <= ssum[SUM_W] ? SUM_MAX : ssum[SUM_W-1:0];
					phase_q <= 2'd0;
				end
			endcase
			if (ctl.frame_clear) begin
				sum_q <= '0;
			end
		end
	end

	assign sim_sum = sum_q;
	assign busy = (phase_q != 2'd0);
endmodule

>>> rtl/ccs_merge.sv
// Merging stage: sums the lane totals and divides by columns times frames with a
// restoring divider, one quotient bit per cycle. Depends on ccs_pkg.
module ccs_merge #(
	parameter int HISTORY_FRAMES = ccs_pkg::DEF_HISTORY_FRAMES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ccs_pkg::SUM_W-1:0] sums [HISTORY_FRAMES],
	input  logic [ccs_pkg::CNT_W-1:0] cols,
	input  logic [ccs_pkg::THR_W-1:0] threshold,
	output logic done,
	output ccs_pkg::res_beat_t result
);
	import ccs_pkg::*;
	localparam int TOT_W = SUM_W + $clog2(HISTORY_FRAMES + 1);
	localparam int DIV_W = CNT_W + 4;
	localparam int CW = $clog2(TOT_W + 1);

	logic [TOT_W-1:0] total, quo_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W:0] rem_q, rem_sh;
	logic [CW-1:0] cnt_q;
	logic [1:0] st_q;
	logic [CNT_W-1:0] cols_q;
	logic [TOT_W-1:0] avg;

	always_comb begin
		total = '0;
		for (int h = 0; h < HISTORY_FRAMES; h++) begin
			total = total + TOT_W'(sums[h]);
		end
		rem_sh = {rem_q[DIV_W-1:0], quo_q[TOT_W-1]};
		avg = (div_q == '0) ? '0 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= 2'd0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				2'd0: begin
					if (start) begin
						quo_q <= total;
						div_q <= DIV_W'(cols) * 4'(HISTORY_FRAMES);
						cols_q <= cols;
						rem_q <= '0;
						cnt_q <= CW'(TOT_W);
						st_q <= 2'd1;
					end
				end
				2'd1: begin
					if (rem_sh >= {1'b0, div_q}) begin
						rem_q <= rem_sh - {1'b0, div_q};
						quo_q <= {quo_q[TOT_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[TOT_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						st_q <= 2'd2;
					end
				end
				default: begin
					result.avg_similarity <= (avg > TOT_W'(ONE_Q15)) ? ONE_Q15 : SIM_W'(avg);
					result.lost_lock <= ((avg > TOT_W'(ONE_Q15)) ? ONE_Q15 : SIM_W'(avg))
						< threshold;
					result.column_count <= cols_q;
					done <= 1'b1;
					st_q <= 2'd0;
				end
			endcase
		end
	end
endmodule

>>> rtl/column_cosine_similarity_lock_check.sv
// Channel  | Dir | Payload
// pix_in   | in  | current pixel, six history pixels, column_end, frame_end
// res_out  | out | avg_similarity, lost_lock, column_count
// A beat without column or frame end starts no search. A column or frame end, while
// fewer than MAX_COLS columns are counted, starts a search in each lane, which blocks
// the next beat. A frame end then runs the merge divider, with input blocked, before
// the result registers. arst_n clears all control state. The result holds while
// res_out.ready is low; beats of the next frame still flow, but its frame end waits
// until the result has left. Depends on ccs_pkg, ccs_if, ccs_lane and ccs_merge.
module column_cosine_similarity_lock_check #(
	parameter int MAX_ROWS = ccs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = ccs_pkg::DEF_MAX_COLS,
	parameter int HISTORY_FRAMES = ccs_pkg::DEF_HISTORY_FRAMES
) (
	input  logic clk,
	input  logic arst_n,
	ccs_pix_if.sink pix_in,
	ccs_res_if.source res_out,
	input  logic cfg_we,
	input  logic [ccs_pkg::THR_W-1:0] cfg_wdata
);
	import ccs_pkg::*;
	localparam int ROW_W = $clog2(MAX_ROWS + 1);

	logic [THR_W-1:0] thr_q;
	logic [ACC_W-1:0] cnorm_q, cnorm_n;
	logic [ACC_W:0] csum;
	logic [CNT_W-1:0] cols_q;
	logic [ROW_W-1:0] rows_q;
	logic [PIX_W-1:0] hp [HISTORY_FRAMES];
	logic [SUM_W-1:0] sums [HISTORY_FRAMES];
	logic [HISTORY_FRAMES-1:0] busy;
	logic frame_pend_q, merge_start_q, merge_run_q, out_valid_q, merge_done, accept, closing;
	lane_ctl_t ctl;
	res_beat_t res;

	assign accept = pix_in.valid && pix_in.ready;
	assign closing = pix_in.data.column_end || pix_in.data.frame_end;
	assign pix_in.ready = (busy == '0) && !frame_pend_q && !merge_start_q && !merge_run_q;
	assign csum = {1'b0, cnorm_q}
		+ (ACC_W+1)'(16'(pix_in.data.cur_pixel) * 16'(pix_in.data.cur_pixel));
	assign cnorm_n = csum[ACC_W] ? ACC_MAX : csum[ACC_W-1:0];

	always_comb begin
		ctl.acc_en = accept;
		ctl.col_close = closing;
		ctl.take = 32'(cols_q) < MAX_COLS;
		ctl.frame_clear = merge_done;
	end

	always_comb begin
		for (int h = 0; h < HISTORY_FRAMES; h++) begin
			case (h)
				0: hp[h] = pix_in.data.hist_pixel_1;
				1: hp[h] = pix_in.data.hist_pixel_2;
				2: hp[h] = pix_in.data.hist_pixel_3;
				3: hp[h] = pix_in.data.hist_pixel_4;
				4: hp[h] = pix_in.data.hist_pixel_5;
				5: hp[h] = pix_in.data.hist_pixel_6;
				default: hp[h] = '0;
			endcase
		end
	end

	for (genvar g = 0; g < HISTORY_FRAMES; g++) begin : g_lane
		ccs_lane u_lane (
			.clk(clk), .arst_n(arst_n), .cur_pixel(pix_in.data.cur_pixel),
			.hist_pixel(hp[g]), .ctl(ctl), .cur_norm(cnorm_n),
			.sim_sum(sums[g]), .busy(busy[g])
		);
	end

	ccs_merge #(.HISTORY_FRAMES(HISTORY_FRAMES)) u_merge (
		.clk(clk), .arst_n(arst_n), .start(merge_start_q), .sums(sums), .cols(cols_q),
		.threshold(thr_q), .done(merge_done), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			cnorm_q <= '0;
			cols_q <= '0;
			rows_q <= '0;
			frame_pend_q <= 1'b0;
			merge_start_q <= 1'b0;
			merge_run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			merge_start_q <= 1'b0;
			if (accept) begin
				if (closing) begin
					cnorm_q <= '0;
					rows_q <= '0;
					if (ctl.take) begin
						cols_q <= cols_q + 1'b1;
					end
					frame_pend_q <= pix_in.data.frame_end;
				end else begin
					cnorm_q <= cnorm_n;
					rows_q <= (32'(rows_q) < MAX_ROWS) ? rows_q + 1'b1 : rows_q;
				end
			end
			if (frame_pend_q && busy == '0 && !out_valid_q) begin
				frame_pend_q <= 1'b0;
				merge_start_q <= 1'b1;
				merge_run_q <= 1'b1;
			end
			if (merge_done) begin
				merge_run_q <= 1'b0;
				out_valid_q <= 1'b1;
				cols_q <= '0;
			end else if (out_valid_q && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data = res;
endmodule

>>> rtl/ccs_checker.sv
// Port-level checker for the lock check block, bound to the top level.
// Depends on ccs_pkg and the top level's ports.
module ccs_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [ccs_pkg::SIM_W-1:0] avg,
	input logic lost
);
	import ccs_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(avg)) else $error("result dropped");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> avg <= ONE_Q15) else $error("average above one");
	a_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid || $stable(lost)) else $error("flag changed");
endmodule

bind column_cosine_similarity_lock_check ccs_checker u_ccs_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.avg(res_out.data.avg_similarity), .lost(res_out.data.lost_lock)
);

>>> bench/ccs_tb_if.sv
`timescale 1ns / 1ps
// Interfaces used by the bench are those of the design (ccs_pix_if, ccs_res_if).
// This file holds the timescale and ccs_tb_pkg with the watchdog limit; depends on ccs_pkg.
package ccs_tb_pkg;
	import ccs_pkg::*;
	localparam int WATCHDOG_LIMIT = 20000;
endpackage

>>> bench/ccs_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the column cosine similarity lock check: it watches both channels
// and the threshold port, predicts each frame result and compares. Depends on ccs_pkg.
module ccs_scoreboard (
	input  logic clk,
	input  logic arst_n,
	ccs_pix_if pix,
	ccs_res_if res,
	input  logic cfg_we,
	input  logic [ccs_pkg::THR_W-1:0] cfg_wdata,
	output int errors,
	output int pending,
	output int frames_seen
);
	import ccs_pkg::*;

	logic [ACC_W-1:0] dot_sum [NUM_INPUT_FRAMES];
	logic [ACC_W-1:0] hist_energy [NUM_INPUT_FRAMES];
	logic [ACC_W-1:0] cur_energy;
	logic [SUM_W-1:0] sim_total [NUM_INPUT_FRAMES];
	logic [CNT_W-1:0] columns;
	logic [THR_W-1:0] threshold;
	res_beat_t frame_results [$];

	function automatic logic [ACC_W-1:0] acc_sat(logic [ACC_W-1:0] a, longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	function automatic longint unsigned cosine_q15(longint unsigned dot,
			longint unsigned nc, longint unsigned nh);
		logic [127:0] rhs, lhs;
		longint unsigned lo, hi, mid;
		if (nc == 0 || nh == 0)
			return 0;
		rhs = (128'(dot) * dot) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			lhs = 128'(mid * mid) * 128'(nc * nh);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic clear_frame();
		for (int h = 0; h < NUM_INPUT_FRAMES; h++) begin
			dot_sum[h] = '0;
			hist_energy[h] = '0;
			sim_total[h] = '0;
		end
		cur_energy = '0;
		columns = '0;
	endtask

	task automatic take_pixel(pix_beat_t b);
		logic [PIX_W-1:0] hp [NUM_INPUT_FRAMES];
		longint unsigned s, total, avg;
		res_beat_t r;
		hp = '{b.hist_pixel_1, b.hist_pixel_2, b.hist_pixel_3,
			b.hist_pixel_4, b.hist_pixel_5, b.hist_pixel_6};
		for (int h = 0; h < NUM_INPUT_FRAMES; h++) begin
			dot_sum[h] = acc_sat(dot_sum[h], 64'(b.cur_pixel) * 64'(hp[h]));
			hist_energy[h] = acc_sat(hist_energy[h], 64'(hp[h]) * 64'(hp[h]));
		end
		cur_energy = acc_sat(cur_energy, 64'(b.cur_pixel) * 64'(b.cur_pixel));
		if (b.column_end || b.frame_end) begin
			for (int h = 0; h < NUM_INPUT_FRAMES; h++) begin
				if (columns < DEF_MAX_COLS) begin
					s = sim_total[h] + cosine_q15(dot_sum[h], cur_energy, hist_energy[h]);
					sim_total[h] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
				end
				dot_sum[h] = '0;
				hist_energy[h] = '0;
			end
			cur_energy = '0;
			if (columns < DEF_MAX_COLS)
				columns++;
		end
		if (b.frame_end) begin
			total = 0;
			avg = 0;
			for (int h = 0; h < NUM_INPUT_FRAMES; h++)
				total += sim_total[h];
			if (columns != 0)
				avg = total / (columns * NUM_INPUT_FRAMES);
			if (avg > ONE_Q15)
				avg = ONE_Q15;
			r.avg_similarity = avg[SIM_W-1:0];
			r.lost_lock = avg < threshold;
			r.column_count = columns;
			frame_results.push_back(r);
			clear_frame();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		if (!arst_n) begin
			clear_frame();
			threshold = THR_RESET;
			frame_results.delete();
			errors = 0;
			frames_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				threshold = cfg_wdata;
			if (pix.valid && pix.ready)
				take_pixel(pix.data);
			if (res.valid && res.ready) begin
				frames_seen++;
				if (frame_results.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = frame_results.pop_front();
					if (res.data.avg_similarity !== want.avg_similarity)
						report("avg_similarity", res.data.avg_similarity, want.avg_similarity);
					if (res.data.lost_lock !== want.lost_lock)
						report("lost_lock", res.data.lost_lock, want.lost_lock);
					if (res.data.column_count !== want.column_count)
						report("column_count", res.data.column_count, want.column_count);
				end
			end
			pending = frame_results.size();
		end
	end
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the bench: drives pixel frames, threshold writes and result back-pressure
// into column_cosine_similarity_lock_check, and gives the verdict from ccs_scoreboard.
module testbench;
	import ccs_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;
	int errors, pending, frames_seen;
	int items_sent, idle_pct, hold_cycles, quiet;

	ccs_pix_if pix();
	ccs_res_if res();

	column_cosine_similarity_lock_check uut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix), .res_out(res),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	ccs_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n), .pix(pix), .res(res), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .errors(errors), .pending(pending),
		.frames_seen(frames_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Valid stays high from one beat to the next unless a random idle gap drops it; wait_drained drops it too.
	task automatic send_pixel(pix_beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			pix.valid <= 0;
			@(negedge clk);
		end
		pix.valid <= 1;
		pix.data <= b;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic pix_beat_t random_pixel(int mode);
		pix_beat_t b;
		b.cur_pixel = 8'($urandom);
		b.hist_pixel_1 = 8'($urandom);
		b.hist_pixel_2 = 8'($urandom);
		b.hist_pixel_3 = 8'($urandom);
		b.hist_pixel_4 = 8'($urandom);
		b.hist_pixel_5 = 8'($urandom);
		b.hist_pixel_6 = 8'($urandom);
		if (mode == 1) begin
			b.hist_pixel_1 = b.cur_pixel;
			b.hist_pixel_2 = b.cur_pixel ^ 8'h01;
			b.hist_pixel_3 = 8'hff - b.cur_pixel;
			b.hist_pixel_4 = b.cur_pixel >> 1;
		end
		b.column_end = 1'b0;
		b.frame_end = 1'b0;
		return b;
	endfunction

	task automatic send_frame(int cols, int rows, int mode);
		pix_beat_t b;
		for (int c = 0; c < cols; c++)
			for (int r = 0; r < rows; r++) begin
				b = random_pixel(mode);
				b.column_end = (r == rows - 1) && (c != cols - 1 || $urandom_range(1));
				b.frame_end = (r == rows - 1) && (c == cols - 1);
				send_pixel(b);
			end
	endtask

	task automatic wait_drained();
		pix.valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		wait_drained();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			res.ready <= 0;
		end else begin
			res.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > ccs_tb_pkg::WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		pix_beat_t b;
		arst_n = 0;
		pix.valid = 0;
		pix.data = '0;
		res.ready = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		idle_pct = 0;
		hold_cycles = 0;
		items_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed frames: extremes, zero norms, lone frame ends.
		b = '1;
		b.column_end = 0;
		b.frame_end = 0;
		send_pixel(b);
		b.column_end = 1;
		send_pixel(b);
		b = '0;
		b.column_end = 1;
		send_pixel(b);
		b.cur_pixel = 8'hff;
		b.hist_pixel_6 = 8'h80;
		b.column_end = 0;
		b.frame_end = 1;
		send_pixel(b);
		b = '0;
		b.frame_end = 1;
		send_pixel(b);
		b.hist_pixel_3 = 8'h01;
		b.cur_pixel = 8'hfe;
		b.column_end = 1;
		send_pixel(b);
		write_threshold(16'd0);
		send_frame(2, 3, 1);
		write_threshold(16'd32768);
		send_frame(3, 2, 1);
		write_threshold(16'hffff);
		send_frame(1, 4, 0);
		write_threshold(THR_RESET);

		// Back-pressure: results blocked while frames keep coming.
		hold_cycles = 400;
		repeat (4) send_frame(1, 2, 1);
		wait_drained();

		// Random frames, first with no idling, then idling on both sides.
		while (items_sent < 800) begin
			idle_pct = (items_sent < 300) ? 0 : 31;
			if ($urandom_range(15) == 0)
				write_threshold(16'($urandom_range(32768)));
			send_frame($urandom_range(1, 5), $urandom_range(1, 6), $urandom_range(1));
		end
		wait_drained();
		$display("Sent %0d pixel beats in %0d frames, varying threshold and stalls.",
			items_sent, frames_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> column_cosine_similarity_lock_check.f
rtl/ccs_pkg.sv
rtl/ccs_if.sv
rtl/ccs_lane.sv
rtl/ccs_merge.sv
rtl/column_cosine_similarity_lock_check.sv
rtl/ccs_checker.sv
bench/ccs_tb_if.sv
bench/ccs_checker.sv
bench/testbench.sv
